@@ rtl/core/cdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque store.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // Store geometry
    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int WORD_W    = 32;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Remainder unit: the sign bit never reaches it, so 31 dividend bits
    localparam int DIV_STEPS = WORD_W - 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_READ       = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast control for the row of storage cells
    typedef struct packed {
        logic shift_fwd;   // every cell takes its front-side neighbor (push front)
        logic shift_back;  // every cell takes its back-side neighbor (pop front)
        logic load;        // selected cell takes the incoming word (push back)
    } cell_ctl_t;

    // Remainder unit request and response
    typedef struct packed {
        logic                start;
        logic [DIV_STEPS-1:0] dividend;
        logic [CNT_W-1:0]    divisor;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } rem_rsp_t;

endpackage

@@ rtl/core/cdq_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cmd_if
// Command channel: one action per transfer.
// ----------------------------------------------------------------------------
interface cdq_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] data_word;
    logic signed [31:0] position;

    modport source (output valid, output action, output data_word, output position,
                    input ready);
    modport sink   (input valid, input action, input data_word, input position,
                    output ready);
endinterface

@@ rtl/core/cdq_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_res_if
// Result channel: one result per command transfer.
// ----------------------------------------------------------------------------
interface cdq_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_word;
    logic [1:0]         status;
    logic               is_empty;
    logic [4:0]         entry_count;

    modport source (output valid, output read_word, output status, output is_empty,
                    output entry_count, input ready);
    modport sink   (input valid, input read_word, input status, input is_empty,
                    input entry_count, output ready);
endinterface

@@ rtl/core/cdq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque row; shifts with its neighbors.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic                              clk,
    input  cdq_pkg::cell_ctl_t                ctl,
    input  logic                              sel,
    input  logic signed [cdq_pkg::WORD_W-1:0] new_word,
    input  logic signed [cdq_pkg::WORD_W-1:0] fwd_word,
    input  logic signed [cdq_pkg::WORD_W-1:0] back_word,
    output logic signed [cdq_pkg::WORD_W-1:0] data_word,
    output logic signed [cdq_pkg::WORD_W-1:0] tap_word
);
    import cdq_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    // Next value: neighbor shift or direct load
    always_comb
    begin
        data_next = data_reg;
        priority if (ctl.shift_fwd)
        begin
            data_next = fwd_word;
        end
        else if (ctl.shift_back)
        begin
            data_next = back_word;
        end
        else if (ctl.load && sel)
        begin
            data_next = new_word;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_word = data_reg;
    // Read tap: zero unless this cell is the selected one, ORed by the top
    assign tap_word  = sel ? data_reg : '0;

endmodule

@@ rtl/core/cdq_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_rem
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module cdq_rem (
    input  logic              clk,
    input  logic              rst_n,
    input  cdq_pkg::rem_req_t req,
    output cdq_pkg::rem_rsp_t rsp
);
    import cdq_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIV_STEPS-1:0] dvd_reg;
    logic [CNT_W-1:0]     div_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [CNT_W:0]       trial;
    logic [CNT_W+1:0]     diff;
    logic                 last_step;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial     = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign diff      = {1'b0, trial} - {2'b00, div_reg};
    assign rem_next  = diff[CNT_W+1] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_STEPS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/core/circular_deque_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_store
// Bounded deque of signed words kept in a row of shifting cells.
// Results: push, pop, clear and reads of an empty store give their result in the
//   cycle after the command transfer; a read with negative position goes via S_FIN.
// A read with non-negative position waits in S_DIV for the 31-step serial
//   remainder of position by the entry count; one command in flight at a time.
// Reset clears count and control; cell contents stay undefined (no clear pass).
// ----------------------------------------------------------------------------
module circular_deque_store (
    input  logic clk,
    input  logic rst_n,
    cdq_cmd_if.sink   cmd,
    cdq_res_if.source res
);
    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     off_reg, off_next;

    logic                 res_valid_reg, res_valid_next;
    logic signed [WORD_W-1:0] res_word_reg, res_word_next;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic                 res_empty_reg, res_empty_next;
    logic [COUNT_OUT_W-1:0] res_count_reg, res_count_next;

    logic                 out_free;
    logic                 cmd_xfer;
    logic                 full;
    logic [CNT_W-1:0]     target;
    cell_ctl_t            ctl;
    rem_req_t             rreq;
    rem_rsp_t             rrsp;

    logic signed [WORD_W-1:0] cell_data [CAPACITY];
    logic signed [WORD_W-1:0] cell_tap  [CAPACITY];
    logic [CAPACITY-1:0]      cell_sel;
    logic signed [WORD_W-1:0] rd_bus;

    assign out_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    // Cell select: back slot when idle, read offset otherwise
    assign target = (state_reg == S_IDLE) ? count_reg : off_reg;

    // Row of storage cells, front at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] fwd_in;
        logic signed [WORD_W-1:0] back_in;

        assign cell_sel[i] = (target == CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign fwd_in = cmd.data_word;
        end
        else
        begin : g_mid
            assign fwd_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign back_in = '0;
        end
        else
        begin : g_inner
            assign back_in = cell_data[i+1];
        end

        cdq_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .sel       (cell_sel[i]),
            .new_word  (cmd.data_word),
            .fwd_word  (fwd_in),
            .back_word (back_in),
            .data_word (cell_data[i]),
            .tap_word  (cell_tap[i])
        );
    end

    // Read bus: OR of the cell taps, only the selected one is nonzero
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_bus = rd_bus | cell_tap[i];
        end
    end

    cdq_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rreq),
        .rsp   (rrsp)
    );

    // Command decode and sequencing
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        off_next        = off_reg;
        ctl             = '0;
        rreq.start      = 1'b0;
        rreq.dividend   = cmd.position[DIV_STEPS-1:0];
        rreq.divisor    = count_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_word_next   = res_word_reg;
        res_status_next = res_status_reg;
        res_empty_next  = res_empty_reg;
        res_count_next  = res_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    res_valid_next  = 1'b1;
                    res_word_next   = '0;
                    res_status_next = ST_OK;
                    unique case (cmd.action)
                        ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.shift_fwd = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.load   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.shift_back = 1'b1;
                                count_next     = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (cmd.position[WORD_W-1])
                            begin
                                // Negative position: last element
                                res_valid_next = res_valid_reg && !res.ready;
                                off_next       = count_reg - CNT_W'(1);
                                state_next     = S_FIN;
                            end
                            else
                            begin
                                res_valid_next = res_valid_reg && !res.ready;
                                rreq.start     = 1'b1;
                                state_next     = S_DIV;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    res_empty_next = (count_next == '0);
                    res_count_next = COUNT_OUT_W'(count_next);
                end
            end
            S_DIV:
            begin
                if (rrsp.done)
                begin
                    off_next   = rrsp.remainder;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_word_next   = rd_bus;
                    res_status_next = ST_OK;
                    res_empty_next  = 1'b0;
                    res_count_next  = COUNT_OUT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        res_word_reg   <= res_word_next;
        res_status_reg <= res_status_next;
        res_empty_reg  <= res_empty_next;
        res_count_reg  <= res_count_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.read_word   = res_word_reg;
    assign res.status      = res_status_reg;
    assign res.is_empty    = res_empty_reg;
    assign res.entry_count = res_count_reg;

endmodule

@@ rtl/core/cdq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque store result channel.
// ----------------------------------------------------------------------------
module cdq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] read_word,
    input logic [1:0]  status,
    input logic        is_empty,
    input logic [4:0]  entry_count
);
    import cdq_pkg::*;

    // A stalled result keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(read_word) && $stable(status)
            && $stable(entry_count))
        else $error("result changed while stalled");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (is_empty == (entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // A dropped push only happens at full capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_FULL) |-> (entry_count == COUNT_OUT_W'(CAPACITY)))
        else $error("full status below capacity");

    // Failed actions return no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (read_word == '0))
        else $error("nonzero read word on failed action");

    // Empty status means the store is empty
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_EMPTY) |-> is_empty)
        else $error("empty status with entries held");

endmodule

bind circular_deque_store cdq_checker u_cdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .read_word   (res.read_word),
    .status      (res.status),
    .is_empty    (res.is_empty),
    .entry_count (res.entry_count)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for circular_deque_store. A short table of directed
// actions (empty store, fill to full, wrap of the front, spare action codes)
// is followed by about 500 random actions biased toward alternate grow and
// drain phases. Results are compared field by field with a typed row or a ring
// model of the store; both channels see random gaps, except over one quiet stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import cdq_pkg::*;

    // Action codes the block leaves unused; they must act as no-ops
    localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_FIRST  = 150;
    localparam int QUIET_LAST   = 299;
    localparam int GAP_PERCENT  = 14;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        status_t                  status;
        logic                     is_empty;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } deque_result_t;

    // One row of the directed table; reps > 1 bumps the data word per transfer
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] data_word;
        logic [WORD_W-1:0] position;
        logic [4:0]        reps;
        logic              typed;
        deque_result_t     want;
    } action_row_t;

    localparam deque_result_t NO_TYPED = '0;
    localparam int DIR_ROWS = 28;

    localparam action_row_t DIRECTED_ACTIONS [DIR_ROWS] = '{
        '{ACT_READ,       32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
        '{ACT_POP_FRONT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1,  1'b1,
          '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
        '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_OK, 1'b0, 5'd1}},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_OK, 1'b0, 5'd2}},
        '{ACT_READ,       32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h8000_0000, ST_OK, 1'b0, 5'd2}},
        '{ACT_READ,       32'h0000_0000, 32'hFFFF_FFFF, 5'd1,  1'b1,
          '{32'h7FFF_FFFF, ST_OK, 1'b0, 5'd2}},
        '{ACT_READ,       32'h0000_0000, 32'h8000_0000, 5'd1,  1'b1,
          '{32'h7FFF_FFFF, ST_OK, 1'b0, 5'd2}},
        '{ACT_READ,       32'h0000_0000, 32'h7FFF_FFFF, 5'd1,  1'b0, NO_TYPED},
        '{ACT_SPARE_LO,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1,  1'b0, NO_TYPED},
        '{ACT_SPARE_MID,  32'h1234_5678, 32'h0000_0001, 5'd1,  1'b0, NO_TYPED},
        '{ACT_SPARE_HI,   32'h8000_0000, 32'h8000_0000, 5'd1,  1'b0, NO_TYPED},
        '{ACT_CLEAR,      32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_OK, 1'b1, 5'd0}},
        '{ACT_PUSH_BACK,  32'h5A5A_0000, 32'h0000_0000, 5'd16, 1'b0, NO_TYPED},
        '{ACT_PUSH_FRONT, 32'hDEAD_BEEF, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_FULL, 1'b0, 5'd16}},
        '{ACT_PUSH_BACK,  32'hDEAD_BEEF, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_FULL, 1'b0, 5'd16}},
        '{ACT_READ,       32'h0000_0000, 32'h0000_000F, 5'd1,  1'b0, NO_TYPED},
        '{ACT_READ,       32'h0000_0000, 32'h0000_0010, 5'd1,  1'b0, NO_TYPED},
        '{ACT_READ,       32'h0000_0000, 32'h7FFF_FFFF, 5'd1,  1'b0, NO_TYPED},
        '{ACT_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 5'd15, 1'b0, NO_TYPED},
        '{ACT_READ,       32'h0000_0000, 32'h0000_0000, 5'd1,  1'b0, NO_TYPED},
        '{ACT_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_OK, 1'b1, 5'd0}},
        '{ACT_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
        '{ACT_PUSH_FRONT, 32'hFFFF_FFF0, 32'h0000_0000, 5'd16, 1'b0, NO_TYPED},
        '{ACT_READ,       32'h0000_0000, 32'hFFFF_FFFE, 5'd1,  1'b0, NO_TYPED},
        '{ACT_POP_FRONT,  32'h0000_0000, 32'h0000_0000, 5'd3,  1'b0, NO_TYPED},
        '{ACT_PUSH_BACK,  32'h0000_0000, 32'h0000_0000, 5'd3,  1'b0, NO_TYPED},
        '{ACT_READ,       32'h0000_0000, 32'h0000_0005, 5'd1,  1'b0, NO_TYPED},
        '{ACT_CLEAR,      32'h0000_0000, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h0, ST_OK, 1'b1, 5'd0}}
    };

    logic clk;
    logic rst_n;

    cdq_cmd_if cmd_bus ();
    cdq_res_if res_bus ();

    circular_deque_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    // Ring model of the store
    logic [WORD_W-1:0] ring_words [CAPACITY];
    int unsigned       head_idx;
    int unsigned       fill_cnt;

    deque_result_t pending_results [$];
    int            mismatch_cnt;
    int            cycle_cnt;
    bit            gaps_on;

    // Apply one action to the ring model and return the result it gives
    function automatic deque_result_t apply_deque_action(logic [ACT_W-1:0] act,
                                                         logic [WORD_W-1:0] word,
                                                         logic [WORD_W-1:0] pos);
        deque_result_t r;
        int unsigned   off;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (fill_cnt >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else if (act == ACT_PUSH_FRONT)
                begin
                    head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
                    ring_words[head_idx] = word;
                    fill_cnt++;
                end
                else
                begin
                    ring_words[(head_idx + fill_cnt) % CAPACITY] = word;
                    fill_cnt++;
                end
            end
            ACT_POP_FRONT:
            begin
                if (fill_cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    head_idx = (head_idx + 1) % CAPACITY;
                    fill_cnt--;
                    // emptied store restarts at slot zero
                    if (fill_cnt == 0)
                        head_idx = 0;
                end
            end
            ACT_READ:
            begin
                if (fill_cnt == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // negative position selects the back element
                    off = pos[WORD_W-1] ? fill_cnt - 1 : pos % fill_cnt;
                    r.read_word = ring_words[(head_idx + off) % CAPACITY];
                end
            end
            ACT_CLEAR:
            begin
                fill_cnt = 0;
                head_idx = 0;
            end
            default:
            begin
            end
        endcase
        r.is_empty    = (fill_cnt == 0);
        r.entry_count = COUNT_OUT_W'(fill_cnt);
        return r;
    endfunction

    // Drive one action, wait for its transfer, then queue what it should give
    task automatic send_action(logic [ACT_W-1:0] act, logic [WORD_W-1:0] word,
                               logic [WORD_W-1:0] pos, bit typed, deque_result_t want);
        deque_result_t model_res;
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.action    <= act;
        cmd_bus.data_word <= word;
        cmd_bus.position  <= pos;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        model_res = apply_deque_action(act, word, pos);
        pending_results.push_back(typed ? want : model_res);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side back-pressure
    initial
    begin
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            res_bus.ready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: read_word %0d status %0d count %0d",
                       res_bus.read_word, res_bus.status, res_bus.entry_count);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.read_word !== want.read_word)
                begin
                    $error("read_word: expected %0d, actual %0d",
                           want.read_word, res_bus.read_word);
                    mismatch_cnt++;
                end
                if (res_bus.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, res_bus.status);
                    mismatch_cnt++;
                end
                if (res_bus.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %0d, actual %0d",
                           want.is_empty, res_bus.is_empty);
                    mismatch_cnt++;
                end
                if (res_bus.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           want.entry_count, res_bus.entry_count);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [ACT_W-1:0]  act;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] pos;
        bit                growing;
        int                phase_left;
        int                roll;
        int                push_share;

        gaps_on           = 1'b1;
        head_idx          = 0;
        fill_cnt          = 0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.action    = ACT_PUSH_FRONT;
        cmd_bus.data_word = '0;
        cmd_bus.position  = '0;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED_ACTIONS[r])
        begin
            for (int i = 0; i < DIRECTED_ACTIONS[r].reps; i++)
                send_action(DIRECTED_ACTIONS[r].action, DIRECTED_ACTIONS[r].data_word + i,
                            DIRECTED_ACTIONS[r].position, DIRECTED_ACTIONS[r].typed,
                            DIRECTED_ACTIONS[r].want);
        end

        // Random actions in alternating grow and drain phases
        growing    = 1'b1;
        phase_left = $urandom_range(20, 60);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= QUIET_FIRST && n <= QUIET_LAST);
            if (phase_left == 0)
            begin
                growing    = !growing;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            push_share = growing ? 50 : 20;

            roll = $urandom_range(0, 99);
            if (roll < 2)
                act = ACT_CLEAR;
            else if (roll < 5)
                act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            else if (roll < 30)
                act = ACT_READ;
            else if (roll < 30 + push_share)
                act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            else
                act = ACT_POP_FRONT;

            word = $urandom;
            roll = $urandom_range(0, 9);
            if (roll < 4)
                pos = $urandom_range(0, 40);
            else if (roll < 6)
                pos = {1'b1, 31'($urandom)};
            else
                pos = $urandom;

            send_action(act, word, pos, 1'b0, NO_TYPED);
        end

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        gaps_on = 1'b1;

        // Drain, then give any stray result time to show up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
